/* hw/rtl/ldfd_pkg.sv */
`default_nettype none

package ldfd_pkg;

  // angle fraction bits of the mean angles and sine arguments
  localparam int AngleFracBits = 16;
  localparam int AngW          = AngleFracBits + 9;
  localparam int AngShift      = 44 - AngleFracBits;
  localparam int ESumShift     = 32 - AngleFracBits;

  typedef logic [AngW-1:0] ang_t;
  typedef logic [AngW+1:0] angx_t;
  typedef logic [AngW+15:0] angv_t;

  localparam ang_t AngFull = ang_t'(64'd360 << AngleFracBits);
  localparam ang_t AngQ1   = ang_t'(64'd90 << AngleFracBits);
  localparam ang_t AngQ2   = ang_t'(64'd180 << AngleFracBits);
  localparam ang_t AngQ3   = ang_t'(64'd270 << AngleFracBits);

  // register map
  localparam logic IdxZone = 1'b0;

  // pipeline: date, residue, 2 reciprocal, T, 4 mean-angle stages, args, 7 sine, 5 sum/bin
  localparam int PipeDepth = 22;

  // T = dint*DivQ0 + floor(residue / DivD) - DivBias, with 2^33 = DivQ0*DivD + DivR0
  localparam logic [16:0] DivD     = 17'd73050;
  localparam logic [16:0] DivQ0    = 17'd117589;
  localparam logic [15:0] DivR0    = 16'd58142;
  localparam logic [34:0] CoffBase = 35'(64'd131072 * 64'd73050 + 64'd36525);
  localparam logic [17:0] DivBias  = 18'd131072;
  // floor(2^36 / DivD); (residue >> 13) * DivRecip >> 23 is low by at most one
  localparam logic [19:0] DivRecip = 20'd940718;

  // degrees per century (12 fraction bits) and offsets (44 fraction bits): D, M1, M
  localparam logic [30:0] MeanRate [3] = '{
    31'((64'd4452671115 * 64'd4096 + 64'd5000) / 64'd10000),
    31'((64'd4771988676 * 64'd4096 + 64'd5000) / 64'd10000),
    31'((64'd359990503 * 64'd4096 + 64'd5000) / 64'd10000)
  };
  localparam logic [63:0] MeanOff [3] = '{
    (64'd29785 * (64'd1 << 44) + 64'd50) / 64'd100,
    (64'd13496 * (64'd1 << 44) + 64'd50) / 64'd100,
    (64'd35753 * (64'd1 << 44) + 64'd50) / 64'd100
  };

  // correction weights for sin M1 (+), sin M (-), sin(2D-M1) (+), sin 2D (+)
  localparam logic [18:0] SinK [4] = '{
    19'((64'd629 * 64'd65536 + 64'd50) / 64'd100),
    19'((64'd210 * 64'd65536 + 64'd50) / 64'd100),
    19'((64'd127 * 64'd65536 + 64'd50) / 64'd100),
    19'((64'd66 * 64'd65536 + 64'd50) / 64'd100)
  };

  localparam logic signed [43:0] EFull = 44'(64'd360 << 32);

  // floor(30.6001 * (m + 1)) for shifted months 3..14
  function automatic logic [8:0] month_days(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd3:    d = 9'd122;
      4'd4:    d = 9'd153;
      4'd5:    d = 9'd183;
      4'd6:    d = 9'd214;
      4'd7:    d = 9'd244;
      4'd8:    d = 9'd275;
      4'd9:    d = 9'd306;
      4'd10:   d = 9'd336;
      4'd11:   d = 9'd367;
      4'd12:   d = 9'd397;
      4'd13:   d = 9'd428;
      4'd14:   d = 9'd459;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lunar_day_from_date_top.sv */
`default_nettype none

// Lunar day (0..27) of a Gregorian date, 0 near new moon.
// Request channel: drive in_cal_year/in_cal_month/in_cal_day with start high;
// the request is taken at a clock edge where start is high and busy is low.
// busy is high only in the first cycle after reset, so one request can be
// taken every cycle from then on.
// Result channel: out_lunar_day is shown with out_strobe for exactly one
// cycle, once the request has passed through the pipeline. Results come
// back in request order. The receiver has no way to stall; a free-running
// 22-stage pipeline sets the latency, the longest part being the
// seven-stage sine evaluation.
// Configuration: APB-style port, zone_hours (signed 5 bits) at address 0,
// written at psel & penable & pwrite; pready is always high. Write it only
// while no request is in flight.
// Reset (rst_n low, synchronous) empties the pipeline, drops any request in
// flight and sets zone_hours to 2.
module lunar_day_from_date_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_cal_year,
  input  logic [3:0]  in_cal_month,
  input  logic [4:0]  in_cal_day,
  output logic        out_strobe,
  output logic [4:0]  out_lunar_day,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                               busy_r;
  logic signed [4:0]                  zone_r;
  logic [ldfd_pkg::PipeDepth-1:0]     vld_r;

  // date stage
  logic [11:0]        yc;
  logic [3:0]         mc;
  logic [23:0]        yr_days;
  logic [23:0]        jint;
  logic signed [17:0] dint_nxt;
  logic signed [17:0] dint_r;

  // zone fix and residue stage
  logic [6:0]         zn;
  logic [22:0]        zp;
  logic signed [17:0] zfx;
  logic [34:0]        coff;
  logic signed [34:0] dx35;
  logic [34:0]        rp_r;
  logic signed [35:0] tb_r;

  // residue / DivD by reciprocal
  logic [41:0]        tp_r;
  logic [34:0]        tn_r;
  logic signed [35:0] tb1_r;
  logic [17:0]        tq_r;
  logic [34:0]        trm_r;
  logic signed [35:0] tb2_r;

  logic signed [35:0] t_r;

  // mean angles: 0 = D, 1 = M1, 2 = M
  logic signed [50:0] ph_r  [3];
  logic [47:0]        pl_r  [3];
  logic signed [65:0] p_r   [3];
  logic [17:0]        mn_r  [3];
  logic [12:0]        mq_r  [3];
  logic [46:0]        mlo_r [3];
  ldfd_pkg::ang_t     ang_r [3];

  // sine arguments and lanes
  ldfd_pkg::angx_t    a2t, a3t;
  ldfd_pkg::ang_t     sa_r   [4];
  ldfd_pkg::ang_t     ddp_r  [8];
  logic [22:0]        sv_r   [4];
  logic [5:0]         sneg_r [4];
  logic [45:0]        sp_r   [4];
  logic [22:0]        sv2_r  [4];
  logic [16:0]        sx_r   [4];
  logic [16:0]        sx2_r  [4];
  logic [16:0]        sx4_r  [4];
  logic [15:0]        si_r   [4];
  logic [16:0]        sx2b_r [4];
  logic [16:0]        sx5_r  [4];
  logic [15:0]        stt_r  [4];
  logic [16:0]        sx6_r  [4];
  logic signed [17:0] ss_r   [4];

  // sum and binning
  logic signed [37:0] ek_r [4];
  ldfd_pkg::ang_t     edd_r;
  logic [43:0]        ddx;
  logic signed [43:0] esum_r;
  logic signed [43:0] ered;
  logic [43:0]        erd_u;
  logic [8:0]         deg;
  logic [17:0]        n2_r;
  logic [31:0]        pq;
  logic [4:0]         q2_r;
  logic [17:0]        n2b_r;
  logic [17:0]        rm;
  logic [4:0]         qf;
  logic [4:0]         lday_r;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      zone_r <= 5'sd2;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[ldfd_pkg::PipeDepth-2:0], start & ~busy_r};
      if (psel && penable && pwrite && pready && paddr[2] == ldfd_pkg::IdxZone) begin
        zone_r <= $signed(pwdata[4:0]);
      end
    end
  end

  assign busy   = busy_r;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ldfd_pkg::IdxZone) ? {{27{zone_r[4]}}, zone_r} : 32'd0;

  // ---------------------------------------------------------------- date
  always_comb begin
    yc = in_cal_year;
    if (in_cal_year < 12'd1901) begin
      yc = 12'd1901;
    end else if (in_cal_year > 12'd2099) begin
      yc = 12'd2099;
    end
    mc = in_cal_month;
    if (mc == 4'd0) begin
      mc = 4'd1;
    end else if (mc > 4'd12) begin
      mc = 4'd12;
    end
    if (mc <= 4'd2) begin
      yc = yc - 12'd1;
      mc = mc + 4'd12;
    end
    // century correction b is -13 for every year in range
    yr_days  = ((24'(yc) + 24'd4716) * 24'd1461) >> 2;
    jint     = yr_days + 24'(ldfd_pkg::month_days(mc)) + 24'(in_cal_day) - 24'd1537;
    dint_nxt = 18'($signed({1'b0, jint}) - 25'sd2451545);
  end

  // zfx = floor((8192*z + 1) / 3) = 2730*z + floor((2z+1)/3)
  always_comb begin
    zn   = {zone_r[4], zone_r, 1'b0} + 7'd34;
    zp   = 23'(zn) * 23'd21846;
    zfx  = 18'sd2730 * $signed({{13{zone_r[4]}}, zone_r})
         + $signed({11'd0, zp[22:16]}) - 18'sd11;
    coff = ldfd_pkg::CoffBase - 35'($signed({{17{zfx[17]}}, zfx}) <<< 17);
    dx35 = $signed({{17{dint_r[17]}}, dint_r});
  end

  always_ff @(posedge clk) begin
    dint_r <= dint_nxt;
    rp_r   <= coff + 35'(dx35 * $signed({19'd0, ldfd_pkg::DivR0}));
    tb_r   <= $signed({{18{dint_r[17]}}, dint_r}) * $signed({19'd0, ldfd_pkg::DivQ0});
  end

  // ---------------------------------------------------------------- residue / DivD
  // estimate from the top 22 bits, then one compare and subtract
  always_ff @(posedge clk) begin
    tp_r  <= 42'(rp_r[34:13]) * 42'(ldfd_pkg::DivRecip);
    tn_r  <= rp_r;
    tb1_r <= tb_r;
    tq_r  <= tp_r[40:23];
    trm_r <= tn_r - 35'(tp_r[40:23]) * 35'(ldfd_pkg::DivD);
    tb2_r <= tb1_r;
  end

  always_ff @(posedge clk) begin
    t_r <= tb2_r
         + $signed({18'd0, tq_r})
         + $signed({35'd0, (trm_r >= 35'(ldfd_pkg::DivD))})
         - $signed({18'd0, ldfd_pkg::DivBias});
  end

  // ---------------------------------------------------------------- mean angles
  for (genvar j = 0; j < 3; j++) begin : g_mean
    logic [19:0] hi_ext;
    logic [17:0] mn;
    logic [34:0] mqp;
    logic [17:0] rr;
    logic [52:0] afull;

    always_comb begin
      // split p mod (360 << 44) into (p >> 47) mod 45 and the low 47 bits
      hi_ext = {p_r[j][65], p_r[j][65:47]};
      mn     = 18'(hi_ext + 20'd65565);
      mqp    = 35'(mn) * 35'd93206;
      rr     = mn_r[j] - 18'(18'(mq_r[j]) * 18'd45);
      if (rr >= 18'd45) begin
        rr = rr - 18'd45;
      end
      afull  = {rr[5:0], mlo_r[j]} >> ldfd_pkg::AngShift;
    end

    always_ff @(posedge clk) begin
      ph_r[j]  <= $signed(t_r[35:17]) * $signed({20'd0, ldfd_pkg::MeanRate[j]});
      pl_r[j]  <= 48'(t_r[16:0]) * 48'(ldfd_pkg::MeanRate[j]);
      p_r[j]   <= ($signed({{15{ph_r[j][50]}}, ph_r[j]}) <<< 17)
                + $signed({18'd0, pl_r[j]})
                + $signed({2'b00, ldfd_pkg::MeanOff[j]});
      mn_r[j]  <= mn;
      mq_r[j]  <= mqp[34:22];
      mlo_r[j] <= p_r[j][46:0];
      ang_r[j] <= afull[ldfd_pkg::AngW-1:0];
    end
  end

  // ---------------------------------------------------------------- sine args
  always_comb begin
    a2t = (ldfd_pkg::angx_t'(ang_r[0]) << 1) + ldfd_pkg::angx_t'(ldfd_pkg::AngFull)
        - ldfd_pkg::angx_t'(ang_r[1]);
    if (a2t >= (ldfd_pkg::angx_t'(ldfd_pkg::AngFull) << 1)) begin
      a2t = a2t - (ldfd_pkg::angx_t'(ldfd_pkg::AngFull) << 1);
    end else if (a2t >= ldfd_pkg::angx_t'(ldfd_pkg::AngFull)) begin
      a2t = a2t - ldfd_pkg::angx_t'(ldfd_pkg::AngFull);
    end
    a3t = ldfd_pkg::angx_t'(ang_r[0]) << 1;
    if (a3t >= ldfd_pkg::angx_t'(ldfd_pkg::AngFull)) begin
      a3t = a3t - ldfd_pkg::angx_t'(ldfd_pkg::AngFull);
    end
  end

  always_ff @(posedge clk) begin
    sa_r[0]  <= ang_r[1];
    sa_r[1]  <= ang_r[2];
    sa_r[2]  <= ldfd_pkg::ang_t'(a2t);
    sa_r[3]  <= ldfd_pkg::ang_t'(a3t);
    ddp_r[0] <= ang_r[0];
    for (int i = 1; i < 8; i++) begin
      ddp_r[i] <= ddp_r[i-1];
    end
  end

  // ---------------------------------------------------------------- sine lanes
  for (genvar l = 0; l < 4; l++) begin : g_sin
    ldfd_pkg::ang_t  a;
    ldfd_pkg::ang_t  rq;
    logic            odd;
    logic            neg;
    ldfd_pkg::angv_t vw;
    logic [16:0]     xe;
    logic [23:0]     chk;
    logic [16:0]     xc;
    logic [33:0]     pxx;
    logic [29:0]     pk;
    logic [32:0]     ptt;
    logic [33:0]     pd;

    always_comb begin
      a   = sa_r[l];
      rq  = a;
      odd = 1'b0;
      neg = 1'b0;
      if (a >= ldfd_pkg::AngQ3) begin
        rq  = a - ldfd_pkg::AngQ3;
        odd = 1'b1;
        neg = 1'b1;
      end else if (a >= ldfd_pkg::AngQ2) begin
        rq  = a - ldfd_pkg::AngQ2;
        neg = 1'b1;
      end else if (a >= ldfd_pkg::AngQ1) begin
        rq  = a - ldfd_pkg::AngQ1;
        odd = 1'b1;
      end
      if (odd) begin
        rq = ldfd_pkg::AngQ1 - rq;
      end
      vw  = {rq, 16'd0} >> ldfd_pkg::AngleFracBits;
      // x = floor(v / 90) by reciprocal, low by at most one
      xe  = sp_r[l][45:29];
      chk = 24'(sv2_r[l]) - 24'(xe) * 24'd90;
      xc  = (chk >= 24'd90) ? xe + 17'd1 : xe;
      pxx = 34'(sx_r[l]) * 34'(sx_r[l]);
      pk  = 30'(sx2_r[l]) * 30'd4639;
      ptt = 33'(si_r[l]) * 33'(sx2b_r[l]);
      pd  = 34'(17'd102944 - 17'(stt_r[l])) * 34'(sx6_r[l]);
    end

    always_ff @(posedge clk) begin
      sv_r[l]   <= vw[22:0];
      sneg_r[l] <= {sneg_r[l][4:0], neg};
      sp_r[l]   <= 46'(sv_r[l]) * 46'd5965232;
      sv2_r[l]  <= sv_r[l];
      sx_r[l]   <= xc;
      sx2_r[l]  <= pxx[32:16];
      sx4_r[l]  <= sx_r[l];
      si_r[l]   <= 16'd42047 - {3'd0, pk[28:16]};
      sx2b_r[l] <= sx2_r[l];
      sx5_r[l]  <= sx4_r[l];
      stt_r[l]  <= ptt[31:16];
      sx6_r[l]  <= sx5_r[l];
      ss_r[l]   <= sneg_r[l][5] ? -$signed({1'b0, pd[32:16]}) : $signed({1'b0, pd[32:16]});
    end
  end

  // ---------------------------------------------------------------- sum and bin
  always_comb begin
    ddx   = 44'(edd_r) << ldfd_pkg::ESumShift;
    ered  = esum_r;
    if (esum_r < 44'sd0) begin
      ered = esum_r + ldfd_pkg::EFull;
    end else if (esum_r >= ldfd_pkg::EFull) begin
      ered = esum_r - ldfd_pkg::EFull;
    end
    erd_u = ered + 44'd2147483648;
    deg   = erd_u[40:32];
    // bin = floor((deg*700 + 4501) / 9000), reciprocal low by at most one
    pq    = 32'(n2_r) * 32'd14913;
    rm    = n2b_r - 18'(18'(q2_r) * 18'd9000);
    qf    = (rm >= 18'd9000) ? q2_r + 5'd1 : q2_r;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      ek_r[l] <= $signed({1'b0, ldfd_pkg::SinK[l]}) * ss_r[l];
    end
    edd_r  <= ddp_r[7];
    esum_r <= $signed(ddx) + 44'(ek_r[0]) - 44'(ek_r[1]) + 44'(ek_r[2]) + 44'(ek_r[3]);
    n2_r   <= 18'(18'(deg) * 18'd700) + 18'd4501;
    q2_r   <= pq[31:27];
    n2b_r  <= n2_r;
    lday_r <= (qf == 5'd28) ? 5'd0 : qf;
  end

  assign out_strobe    = vld_r[ldfd_pkg::PipeDepth-1];
  assign out_lunar_day = lday_r;

  // ---------------------------------------------------------------- checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(ldfd_pkg::PipeDepth) out_strobe)
    else $error("accepted request produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, ldfd_pkg::PipeDepth))
    else $error("result without a request");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_lunar_day <= 5'd27)
    else $error("lunar day out of range");

  a_angles: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[8] |-> (ang_r[0] < ldfd_pkg::AngFull) && (ang_r[1] < ldfd_pkg::AngFull)
                 && (ang_r[2] < ldfd_pkg::AngFull))
    else $error("mean angle not reduced");

  a_flush: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");

endmodule

`default_nettype wire
